[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/bs_pkg.sv]
package bs_pkg;

  localparam int DEFAULT_MAX_SLOTS = 64;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 6;
  localparam int WEIGHT_W = 8;
  localparam int STATUS_W = 2;
  localparam int CONN_W   = 16;
  localparam int POLICY_W = 3;
  localparam int LFSR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [OPCODE_W-1:0] OP_SELECT  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [POLICY_W-1:0] POL_RR     = 3'd0;
  localparam logic [POLICY_W-1:0] POL_LEAST  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_RANDOM = 3'd2;
  localparam logic [POLICY_W-1:0] POL_POSW   = 3'd3;
  localparam logic [POLICY_W-1:0] POL_FIRST  = 3'd4;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [CONN_W-1:0]   connections;
  } out_item_t;

endpackage

[rtl/core/bs_ram.sv]
module bs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bs_mod.sv]
module bs_mod #(
  parameter int MAX_SLOTS = bs_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bs_pkg::LFSR_W-1:0]        dividend,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]   divisor,
  output logic                             done,
  output logic [$clog2(MAX_SLOTS+1)-1:0]   remainder
);

  import bs_pkg::*;

  localparam int CW     = $clog2(MAX_SLOTS + 1);
  localparam int STEP_W = $clog2(LFSR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [LFSR_W-1:0] quo_sh;
  logic [CW-1:0]     rem;
  logic [CW:0]       trial;
  logic [CW:0]       diff;

  assign trial     = {rem, quo_sh[LFSR_W-1]};
  assign diff      = trial - {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        step   <= '0;
        rem    <= '0;
        quo_sh <= dividend;
      end else if (busy) begin
        rem    <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
        quo_sh <= {quo_sh[LFSR_W-2:0], 1'b0};
        step   <= step + STEP_W'(1);
        if (step == STEP_W'(LFSR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/backend_selector.sv]
// Backend table with MAX_SLOTS slots and one operation per transfer. Release goes
// through the fetch and update states, remove straight to done. Add and the least
// connections, positive weight and first valid selects scan the slot RAM one slot
// per cycle through its single read port and stop at the first hit where the policy
// allows it. Round robin and random selects first run the bit-serial remainder unit
// and then scan for the chosen slot. A new item is taken once the result has moved
// to the output register, which holds it until it is taken.
module backend_selector #(
  parameter int MAX_SLOTS = bs_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bs_pkg::in_item_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bs_pkg::out_item_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bs_pkg::ADDR_W-1:0] paddr,
  input  logic [bs_pkg::DATA_W-1:0] pwdata,
  output logic [bs_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  import bs_pkg::*;

  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int ENT_W = WEIGHT_W + CONN_W;
  localparam logic [IW-1:0] LAST = IW'(MAX_SLOTS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [2:0] M_FREE  = 3'd0;
  localparam logic [2:0] M_NTH   = 3'd1;
  localparam logic [2:0] M_POSW  = 3'd2;
  localparam logic [2:0] M_LEAST = 3'd3;
  localparam logic [2:0] M_FIRST = 3'd4;

  logic [2:0]           state;
  logic [POLICY_W-1:0]  policy;
  logic [LFSR_W-1:0]    seed;
  logic [LFSR_W-1:0]    lfsr;
  logic [MAX_SLOTS-1:0] valid;
  logic [CW-1:0]        active;
  logic [IW-1:0]        rr_ptr;
  logic                 issuing;
  logic                 pend;

  in_item_t             item;
  logic [POLICY_W-1:0]  pol;
  logic [2:0]           mode;
  logic [IW-1:0]        cnt;
  logic [IW-1:0]        pidx;
  logic [IW-1:0]        seen;
  logic [IW-1:0]        ord;
  logic                 have;
  logic [IW-1:0]        best;
  logic [CONN_W-1:0]    best_conn;
  out_item_t            res;

  logic                 accept;
  logic                 cfg_we;
  logic [POLICY_W-1:0]  eff;
  logic [LFSR_W-1:0]    lfsr_step;
  logic [IW-1:0]        sidx;
  logic                 slot_in_rng;
  logic                 slot_ok;
  logic                 mod_start;
  logic [LFSR_W-1:0]    mod_dividend;
  logic                 mod_done;
  logic [CW-1:0]        mod_rem;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [ENT_W-1:0]     rdata;
  logic [WEIGHT_W-1:0]  ent_w;
  logic [CONN_W-1:0]    ent_c;
  logic                 cur_v;
  logic                 hit;
  logic                 better;
  logic                 take;
  logic                 last;
  logic                 found;
  logic [IW-1:0]        fin_best;
  logic [CONN_W-1:0]    newc;
  logic [CW-1:0]        ord_inc;
  logic [IW-1:0]        rr_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_POLICY) ? DATA_W'(policy) : DATA_W'(seed);

  assign eff       = (policy > POL_FIRST) ? POL_FIRST : policy;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  assign sidx        = IW'(in_data.slot);
  assign slot_in_rng = (int'(in_data.slot) < MAX_SLOTS);
  assign slot_ok     = slot_in_rng ? valid[sidx] : 1'b0;

  assign mod_start    = accept && (in_data.opcode == OP_SELECT) && (active != '0) &&
                        (eff inside {POL_RR, POL_RANDOM});
  assign mod_dividend = (eff == POL_RANDOM) ? lfsr_step : LFSR_W'(rr_ptr);

  bs_mod #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_bs_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (active),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  assign ent_w = rdata[CONN_W +: WEIGHT_W];
  assign ent_c = rdata[CONN_W-1:0];

  always_comb begin
    cur_v  = valid[pidx];
    hit    = 1'b0;
    better = 1'b0;
    case (mode)
      M_FREE:  hit    = !cur_v;
      M_NTH:   hit    = cur_v && (seen == ord);
      M_POSW:  hit    = cur_v && (ent_w != '0);
      M_LEAST: better = cur_v && (!have || (ent_c < best_conn));
      M_FIRST: hit    = cur_v;
      default: hit    = 1'b0;
    endcase
    take     = pend && (hit || better);
    last     = pend && (hit || (pidx == LAST));
    fin_best = take ? pidx : best;
    found    = take || have;
  end

  always_comb begin
    if (item.opcode == OP_SELECT) begin
      newc = (ent_c == '1) ? ent_c : ent_c + CONN_W'(1);
    end else begin
      newc = (ent_c == '0) ? ent_c : ent_c - CONN_W'(1);
    end
    ord_inc = CW'(ord) + CW'(1);
    rr_next = (ord_inc == active) ? '0 : IW'(ord_inc);
  end

  always_comb begin
    ram_raddr = (state == S_SCAN) ? cnt : best;
    ram_we    = 1'b0;
    ram_waddr = best;
    ram_wdata = {ent_w, newc};
    if (state == S_UPDATE) begin
      ram_we = 1'b1;
    end else if ((state == S_SCAN) && last && found && (item.opcode == OP_ADD)) begin
      ram_we    = 1'b1;
      ram_waddr = fin_best;
      ram_wdata = {item.weight, CONN_W'(0)};
    end
  end

  bs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SLOTS)
  ) u_bs_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      active    <= '0;
      rr_ptr    <= '0;
      policy    <= POL_RR;
      seed      <= LFSR_W'(1);
      lfsr      <= LFSR_W'(1);
      issuing   <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_POLICY) begin
          policy <= pwdata[POLICY_W-1:0];
        end else begin
          seed <= pwdata[LFSR_W-1:0];
          lfsr <= (pwdata[LFSR_W-1:0] == '0) ? LFSR_W'(1) : pwdata[LFSR_W-1:0];
        end
      end
      if (accept && (in_data.opcode == OP_SELECT) && (eff == POL_RANDOM)) begin
        lfsr <= lfsr_step;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              OP_SELECT: begin
                if (active == '0) begin
                  state <= S_DONE;
                end else if (eff inside {POL_RR, POL_RANDOM}) begin
                  state <= S_MOD;
                end else begin
                  state   <= S_SCAN;
                  issuing <= 1'b1;
                  pend    <= 1'b0;
                end
              end
              OP_RELEASE: begin
                state <= slot_ok ? S_FETCH : S_DONE;
              end
              OP_REMOVE: begin
                if (slot_ok) begin
                  valid[sidx] <= 1'b0;
                  active      <= active - CW'(1);
                  if (active == CW'(1)) begin
                    rr_ptr <= '0;
                  end
                end
                state <= S_DONE;
              end
              default: begin
                state   <= S_SCAN;
                issuing <= 1'b1;
                pend    <= 1'b0;
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state   <= S_SCAN;
            issuing <= 1'b1;
            pend    <= 1'b0;
          end
        end
        S_SCAN: begin
          pend <= issuing;
          if (issuing && (cnt == LAST)) begin
            issuing <= 1'b0;
          end
          if (last) begin
            issuing <= 1'b0;
            pend    <= 1'b0;
            if (!found) begin
              state <= S_DONE;
            end else if (item.opcode == OP_ADD) begin
              valid[fin_best] <= 1'b1;
              active          <= active + CW'(1);
              state           <= S_DONE;
            end else begin
              if (pol == POL_RR) begin
                rr_ptr <= rr_next;
              end
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          item <= in_data;
          pol  <= eff;
          cnt  <= '0;
          seen <= '0;
          have <= 1'b0;
          best <= sidx;
          res.status          <= ((in_data.opcode == OP_REMOVE) && slot_ok) ? ST_OK : ST_NONE;
          res.chosen_slot     <= (in_data.opcode == OP_SELECT) ? '0 : in_data.slot;
          res.connections     <= '0;
          if (in_data.opcode == OP_ADD) begin
            mode <= M_FREE;
          end else if (eff == POL_LEAST) begin
            mode <= M_LEAST;
          end else if (eff == POL_POSW) begin
            mode <= M_POSW;
          end else begin
            mode <= M_FIRST;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          ord  <= IW'(mod_rem);
          mode <= M_NTH;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          pidx <= cnt;
          if (cnt != LAST) begin
            cnt <= cnt + IW'(1);
          end
        end
        if (pend) begin
          if ((mode == M_NTH) && cur_v && !hit) begin
            seen <= seen + IW'(1);
          end
          if (take) begin
            have      <= 1'b1;
            best      <= pidx;
            best_conn <= ent_c;
          end
        end
        if (last) begin
          if (item.opcode == OP_ADD) begin
            res.status      <= found ? ST_OK : ST_FULL;
            res.chosen_slot <= found ? SLOT_W'(fin_best) : '0;
          end else begin
            res.status      <= ST_NONE;
            res.chosen_slot <= '0;
          end
          res.connections <= '0;
        end
      end
      S_UPDATE: begin
        res.status      <= ST_OK;
        res.chosen_slot <= SLOT_W'(best);
        res.connections <= newc;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/bs_checker.sv]
`include "assert_macros.svh"

module bs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bs_pkg::out_item_t out_data
);

  import bs_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input taken while an item is at work")
  `ASSERT_ALWAYS(a_status_code, clk, rst, !out_valid || (out_data.status != 2'd3), "undefined status code")
  `ASSERT_ALWAYS(a_fail_fields, clk, rst, !out_valid || (out_data.status == ST_OK) || (out_data.connections == '0), "failed operation reports connections")
  `ASSERT_ALWAYS(a_full_slot, clk, rst, !out_valid || (out_data.status != ST_FULL) || (out_data.chosen_slot == '0), "full table reports a slot")

endmodule

bind backend_selector bs_checker u_bs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
